// File: sv/connection_slot_table_evict_oldest_assert.svh
// Assertion macros for the connection slot table.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef CONNECTION_SLOT_TABLE_EVICT_OLDEST_ASSERT_SVH
`define CONNECTION_SLOT_TABLE_EVICT_OLDEST_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CSTEO_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CSTEO_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/csteo_pkg.sv
// Shared constants and codes for the connection slot table.
// Used by connection_slot_table_evict_oldest; depends on nothing else.
`default_nettype none

package csteo_pkg;

    localparam int SLOTS    = 16;
    localparam int KEY_BITS = 16;
    localparam int AGE_BITS = 32;

    localparam int SLOT_IW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam int FUNC_W   = 2;
    localparam int CKEY_W   = 16;
    localparam int STATUS_W = 2;
    localparam int SIDX_W   = 4;
    localparam int VKEY_W   = 16;

    localparam int S_TDATA_W = ((CKEY_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((SIDX_W + VKEY_W + 7) / 8) * 8;

    typedef enum logic [FUNC_W-1:0] {
        OP_REGISTER    = 2'd0,
        OP_UNREGISTER  = 2'd1,
        OP_FIND_OLDEST = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE = 2'd0,
        ST_FULL = 2'd1,
        ST_NONE = 2'd2
    } status_t;

endpackage

`default_nettype wire

// File: sv/connection_slot_table_evict_oldest.sv
// Connection slot table with register, unregister and find-oldest requests.
// Depends on csteo_pkg and connection_slot_table_evict_oldest_assert.svh.
//
//  channel | group                  | payload
//  --------+------------------------+------------------------------------------
//  request | s_tvalid/s_tready      | s_tuser: func; s_tdata: conn_key
//  result  | m_tvalid/m_tready      | m_tuser: status; m_tdata: slot_index,
//          |                        | victim_key
//
// An item passes the accept step, a scan of the slots in turn through the single key/age
// comparator, and a posting step that posts the result and updates the chosen slot.
// A stalled result port holds the item at the posting step.
// A new item is accepted whenever the scan is idle, even while a result waits.
// Reset clears the used marks and the arrival counter at once; no clearing pass.
`default_nettype none

`include "connection_slot_table_evict_oldest_assert.svh"

module connection_slot_table_evict_oldest (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [csteo_pkg::S_TDATA_W-1:0]  s_tdata,   // [15:0] conn_key
    input  wire logic [csteo_pkg::FUNC_W-1:0]     s_tuser,   // [1:0] func
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [csteo_pkg::M_TDATA_W-1:0]       m_tdata,   // [3:0] slot_index,
                                                             // [19:4] victim_key
    output logic [csteo_pkg::STATUS_W-1:0]        m_tuser    // [1:0] status
);

    localparam int IW = csteo_pkg::SLOT_IW;
    localparam int KW = csteo_pkg::KEY_BITS;
    localparam int AW = csteo_pkg::AGE_BITS;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RESP
    } state_t;

    state_t                            state_reg;
    logic [csteo_pkg::SLOTS-1:0]       used_reg;
    logic [KW-1:0]                     key_mem [csteo_pkg::SLOTS];
    logic [AW-1:0]                     age_mem [csteo_pkg::SLOTS];
    logic [AW-1:0]                     counter_reg;
    logic [csteo_pkg::FUNC_W-1:0]      func_reg;
    logic [KW-1:0]                     req_key_reg;
    logic [IW-1:0]                     scan_reg;
    logic                              hit_reg;
    logic [IW-1:0]                     hit_idx_reg;
    logic [AW-1:0]                     best_age_reg;
    logic [KW-1:0]                     best_key_reg;
    logic                              m_tvalid_reg;
    logic [csteo_pkg::M_TDATA_W-1:0]   m_tdata_reg;
    logic [csteo_pkg::STATUS_W-1:0]    m_tuser_reg;

    logic [KW+csteo_pkg::CKEY_W-1:0]   in_key_ext;
    logic [KW-1:0]                     in_key;
    logic                              cur_used;
    logic [KW-1:0]                     cur_key;
    logic [AW-1:0]                     cur_age;
    logic                              take;
    logic                              scan_last;
    logic                              out_free;
    logic [IW+csteo_pkg::SIDX_W-1:0]   idx_ext;
    logic [KW+csteo_pkg::VKEY_W-1:0]   vkey_ext;
    csteo_pkg::status_t                res_status;
    logic                              wr_reg;
    logic                              wr_unreg;

    // The request key is fitted to the stored key width.
    assign in_key_ext = {{KW{1'b0}}, s_tdata[csteo_pkg::CKEY_W-1:0]};
    assign in_key     = in_key_ext[KW-1:0];

    assign cur_used  = used_reg[scan_reg];
    assign cur_key   = key_mem[scan_reg];
    assign cur_age   = age_mem[scan_reg];
    assign scan_last = (scan_reg == IW'(csteo_pkg::SLOTS - 1));
    assign out_free  = !m_tvalid_reg || m_tready;

    // Shared compare step: decides whether the slot under the scan pointer is taken.
    always_comb
    begin
        case (csteo_pkg::op_t'(func_reg))
            csteo_pkg::OP_REGISTER:    take = !hit_reg && !cur_used;
            csteo_pkg::OP_UNREGISTER:  take = !hit_reg && cur_used && (cur_key == req_key_reg);
            csteo_pkg::OP_FIND_OLDEST: take = cur_used && (cur_key != '0)
                                              && (cur_age < best_age_reg);
            default:                   take = 1'b0;
        endcase
    end

    always_comb
    begin
        case (csteo_pkg::op_t'(func_reg))
            csteo_pkg::OP_REGISTER:
                res_status = hit_reg ? csteo_pkg::ST_DONE : csteo_pkg::ST_FULL;
            csteo_pkg::OP_UNREGISTER,
            csteo_pkg::OP_FIND_OLDEST:
                res_status = hit_reg ? csteo_pkg::ST_DONE : csteo_pkg::ST_NONE;
            default:
                res_status = csteo_pkg::ST_NONE;
        endcase
    end

    assign idx_ext  = {{csteo_pkg::SIDX_W{1'b0}}, (hit_reg ? hit_idx_reg : '0)};
    assign vkey_ext = {{csteo_pkg::VKEY_W{1'b0}},
                       ((hit_reg && (func_reg == csteo_pkg::OP_FIND_OLDEST))
                        ? best_key_reg : '0)};

    assign wr_reg   = (state_reg == S_RESP) && out_free && hit_reg
                      && (func_reg == csteo_pkg::OP_REGISTER);
    assign wr_unreg = (state_reg == S_RESP) && out_free && hit_reg
                      && (func_reg == csteo_pkg::OP_UNREGISTER);

    // Key and age entries carry no reset; they are only read behind a used mark.
    always_ff @(posedge clk)
    begin
        if (wr_reg)
        begin
            key_mem[hit_idx_reg] <= req_key_reg;
            age_mem[hit_idx_reg] <= counter_reg;
        end
        else if (wr_unreg)
        begin
            key_mem[hit_idx_reg] <= '0;
            age_mem[hit_idx_reg] <= '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            used_reg     <= '0;
            counter_reg  <= '0;
            func_reg     <= '0;
            req_key_reg  <= '0;
            scan_reg     <= '0;
            hit_reg      <= 1'b0;
            hit_idx_reg  <= '0;
            best_age_reg <= '0;
            best_key_reg <= '0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            m_tuser_reg  <= '0;
        end
        else
        begin
            // In the posting state the result register is handled there, since a taken
            // result is replaced by the new one in the same cycle.
            if (m_tvalid_reg && m_tready && (state_reg != S_RESP))
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        func_reg     <= s_tuser;
                        req_key_reg  <= in_key;
                        scan_reg     <= '0;
                        hit_reg      <= 1'b0;
                        hit_idx_reg  <= '0;
                        best_age_reg <= '1;
                        best_key_reg <= '0;
                        // The counter moves on every register request, full or not.
                        if (s_tuser == csteo_pkg::OP_REGISTER)
                        begin
                            counter_reg <= counter_reg + AW'(1);
                        end
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (take)
                    begin
                        hit_reg      <= 1'b1;
                        hit_idx_reg  <= scan_reg;
                        best_age_reg <= cur_age;
                        best_key_reg <= cur_key;
                    end
                    if (scan_last)
                    begin
                        state_reg <= S_RESP;
                    end
                    else
                    begin
                        scan_reg <= scan_reg + IW'(1);
                    end
                end
                S_RESP:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tuser_reg  <= res_status;
                        m_tdata_reg  <= csteo_pkg::M_TDATA_W'({vkey_ext[csteo_pkg::VKEY_W-1:0],
                                                                 idx_ext[csteo_pkg::SIDX_W-1:0]});
                        if (wr_reg)
                        begin
                            used_reg[hit_idx_reg] <= 1'b1;
                        end
                        else if (wr_unreg)
                        begin
                            used_reg[hit_idx_reg] <= 1'b0;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `CSTEO_ASSERT_SAME(a_fail_fields_zero,
        m_tvalid && (m_tuser != csteo_pkg::ST_DONE), m_tdata == '0,
        "failed result carries a nonzero slot index or key")
    `CSTEO_ASSERT_NEXT(a_accept_starts_scan,
        s_tvalid && s_tready, (state_reg == S_SCAN) && (scan_reg == '0) && !hit_reg,
        "accepted item did not start a scan from the first slot")
    `CSTEO_ASSERT_NEXT(a_counter_bumps,
        s_tvalid && s_tready && (s_tuser == csteo_pkg::OP_REGISTER),
        counter_reg == $past(counter_reg) + AW'(1),
        "arrival counter did not advance on a register request")
    `CSTEO_ASSERT_SAME(a_victim_has_key,
        m_tvalid && (m_tdata[csteo_pkg::SIDX_W+csteo_pkg::VKEY_W-1:csteo_pkg::SIDX_W] != '0),
        m_tuser == csteo_pkg::ST_DONE,
        "victim key reported with a failing status")

endmodule

`default_nettype wire

// File: dv/connection_slot_table_evict_oldest_checker.sv
// Checker for the connection slot table: watches both stream channels, keeps its own
// copy of the table and compares every result item. Depends on csteo_pkg only.
`timescale 1ns / 1ps

module connection_slot_table_evict_oldest_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [csteo_pkg::S_TDATA_W-1:0] s_tdata,   // [15:0] conn_key
    input  logic [csteo_pkg::FUNC_W-1:0]    s_tuser,   // [1:0] func
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [csteo_pkg::M_TDATA_W-1:0] m_tdata,   // [3:0] slot_index, [19:4] victim_key
    input  logic [csteo_pkg::STATUS_W-1:0]  m_tuser,   // [1:0] status
    output int                              mismatches,
    output int                              outstanding
);

    typedef struct packed {
        csteo_pkg::status_t                status;
        logic [csteo_pkg::SIDX_W-1:0]      slot;
        logic [csteo_pkg::VKEY_W-1:0]      victim;
    } slot_result_t;

    logic                           slot_used [csteo_pkg::SLOTS];
    logic [csteo_pkg::KEY_BITS-1:0] slot_key  [csteo_pkg::SLOTS];
    logic [csteo_pkg::AGE_BITS-1:0] slot_age  [csteo_pkg::SLOTS];
    logic [csteo_pkg::AGE_BITS-1:0] arrival_count;

    slot_result_t expected_results[$];

    assign outstanding = expected_results.size();

    // Applies one request to the shadow table and returns the result it should give.
    function automatic slot_result_t apply_request(
        input logic [csteo_pkg::FUNC_W-1:0] func,
        input logic [csteo_pkg::CKEY_W-1:0] key);
        slot_result_t                   r;
        int                             i;
        int                             best;
        logic [csteo_pkg::AGE_BITS-1:0] best_age;
        bit                             hit;
        r.status = csteo_pkg::ST_NONE;
        r.slot   = '0;
        r.victim = '0;
        hit      = 1'b0;
        case (func)
            csteo_pkg::OP_REGISTER:
            begin
                // The counter moves even when no slot is free.
                arrival_count = arrival_count + 1'b1;
                r.status = csteo_pkg::ST_FULL;
                for (i = 0; i < csteo_pkg::SLOTS; i++)
                begin
                    if (!hit && !slot_used[i])
                    begin
                        slot_used[i] = 1'b1;
                        slot_key[i]  = key;
                        slot_age[i]  = arrival_count;
                        r.status     = csteo_pkg::ST_DONE;
                        r.slot       = csteo_pkg::SIDX_W'(i);
                        hit          = 1'b1;
                    end
                end
            end
            csteo_pkg::OP_UNREGISTER:
            begin
                for (i = 0; i < csteo_pkg::SLOTS; i++)
                begin
                    if (!hit && slot_used[i] && slot_key[i] == key)
                    begin
                        slot_used[i] = 1'b0;
                        slot_key[i]  = '0;
                        slot_age[i]  = '0;
                        r.status     = csteo_pkg::ST_DONE;
                        r.slot       = csteo_pkg::SIDX_W'(i);
                        hit          = 1'b1;
                    end
                end
            end
            csteo_pkg::OP_FIND_OLDEST:
            begin
                // Strict compare against an all-ones start: an all-ones age never wins,
                // ties go to the lowest slot, and zero keys are skipped.
                best     = -1;
                best_age = '1;
                for (i = 0; i < csteo_pkg::SLOTS; i++)
                begin
                    if (slot_used[i] && slot_key[i] != '0 && slot_age[i] < best_age)
                    begin
                        best_age = slot_age[i];
                        best     = i;
                    end
                end
                if (best >= 0)
                begin
                    r.status = csteo_pkg::ST_DONE;
                    r.slot   = csteo_pkg::SIDX_W'(best);
                    r.victim = slot_key[best];
                end
            end
            default:
            begin
                r.status = csteo_pkg::ST_NONE;
            end
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        slot_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < csteo_pkg::SLOTS; i++)
            begin
                slot_used[i] = 1'b0;
                slot_key[i]  = '0;
                slot_age[i]  = '0;
            end
            arrival_count = '0;
            mismatches    = 0;
            expected_results.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"%0t: result item with nothing expected: ",
                                  "status %0d slot %0d key %h"},
                                 $realtime, m_tuser, m_tdata[3:0], m_tdata[19:4]);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (want.status !== m_tuser || want.slot !== m_tdata[3:0] ||
                        want.victim !== m_tdata[19:4])
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%0t: mismatch: expected status %0d slot %0d key %h, ",
                                      "got status %0d slot %0d key %h"},
                                     $realtime, want.status, want.slot, want.victim,
                                     m_tuser, m_tdata[3:0], m_tdata[19:4]);
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_results.push_back(
                    apply_request(s_tuser, s_tdata[csteo_pkg::CKEY_W-1:0]));
        end
    end

endmodule

// File: dv/connection_slot_table_evict_oldest_tb.sv
// Top of the connection slot table testbench: clock, reset, request and result traffic.
// Depends on csteo_pkg, the block and connection_slot_table_evict_oldest_checker.
`timescale 1ns / 1ps

module connection_slot_table_evict_oldest_tb;

    localparam logic [csteo_pkg::FUNC_W-1:0] OP_UNKNOWN  = 2'd3;
    localparam int                           RAND_ITEMS  = 700;
    localparam int                           CYCLE_LIMIT = 200000;

    logic                            clk;
    logic                            rst_n;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [csteo_pkg::S_TDATA_W-1:0] s_tdata;
    logic [csteo_pkg::FUNC_W-1:0]    s_tuser;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [csteo_pkg::M_TDATA_W-1:0] m_tdata;
    logic [csteo_pkg::STATUS_W-1:0]  m_tuser;
    int                              mismatches;
    int                              outstanding;
    int                              cycles;
    bit                              sender_idles;
    logic [csteo_pkg::CKEY_W-1:0]    key_pool [20];

    connection_slot_table_evict_oldest i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    connection_slot_table_evict_oldest_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("== FAIL ==");
        $finish;
    end

    // Result side: random stalls, one long hold-off that backs the block up into its
    // request port, and a stretch with no stalls at all.
    initial
    begin
        int rx_cycle;
        rx_cycle = 0;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            rx_cycle++;
            if (rx_cycle >= 3000 && rx_cycle < 3400)
                m_tready <= 1'b0;
            else if (rx_cycle >= 6000 && rx_cycle < 8000)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(0, 99) >= 31);
        end
    end

    // Offers one request item and returns at the edge where it is accepted.
    task automatic offer_request(input logic [csteo_pkg::FUNC_W-1:0] func,
                                 input logic [csteo_pkg::CKEY_W-1:0] key);
        while (sender_idles && $urandom_range(0, 99) < 31)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= key;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    initial
    begin
        int          reg_share;
        int          pick;
        logic [15:0] key;
        rst_n        <= 1'b0;
        s_tvalid     <= 1'b0;
        s_tdata      <= '0;
        s_tuser      <= csteo_pkg::OP_REGISTER;
        sender_idles = 1'b1;
        key_pool[0]  = 16'h0000;
        key_pool[1]  = 16'hFFFF;
        key_pool[2]  = 16'h0001;
        for (int i = 3; i < 20; i++)
            key_pool[i] = 16'($urandom);
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: empty table, unknown operation, zero key, fill to full,
        // then free and reuse the lowest slots.
        offer_request(csteo_pkg::OP_FIND_OLDEST, 16'h0000);
        offer_request(csteo_pkg::OP_UNREGISTER, 16'h0005);
        offer_request(OP_UNKNOWN, 16'hFFFF);
        offer_request(csteo_pkg::OP_REGISTER, 16'h0000);
        offer_request(csteo_pkg::OP_FIND_OLDEST, 16'hFFFF);
        offer_request(csteo_pkg::OP_REGISTER, 16'hFFFF);
        offer_request(csteo_pkg::OP_REGISTER, 16'h0001);
        for (int i = 3; i < csteo_pkg::SLOTS; i++)
            offer_request(csteo_pkg::OP_REGISTER, 16'h1000 + 16'(i));
        offer_request(csteo_pkg::OP_REGISTER, 16'hAAAA);
        offer_request(csteo_pkg::OP_FIND_OLDEST, 16'h0000);
        offer_request(csteo_pkg::OP_UNREGISTER, 16'h0000);
        offer_request(csteo_pkg::OP_UNREGISTER, 16'hFFFF);
        offer_request(csteo_pkg::OP_REGISTER, 16'h5555);
        offer_request(csteo_pkg::OP_FIND_OLDEST, 16'h0000);

        // Random part: the mix swings between filling and draining the table so that
        // both the full and the empty cases recur. Keys mostly come from a small pool
        // so that unregisters find their match.
        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            sender_idles = !(n >= 300 && n < 420);
            reg_share    = ((n / 100) % 2 == 0) ? 55 : 25;
            pick         = $urandom_range(0, 99);
            if ($urandom_range(0, 9) == 0)
                key = 16'($urandom);
            else
                key = key_pool[$urandom_range(0, 19)];
            if (pick < reg_share)
                offer_request(csteo_pkg::OP_REGISTER, key);
            else if (pick < reg_share + 30)
                offer_request(csteo_pkg::OP_UNREGISTER, key);
            else if (pick < 95)
                offer_request(csteo_pkg::OP_FIND_OLDEST, key);
            else
                offer_request(OP_UNKNOWN, key);
        end
        s_tvalid <= 1'b0;

        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
